// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge outside reset
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent on the next edge
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/tds_pkg.sv =====
// package for the tridiagonal solver: word types, limits and helpers
package tds_pkg;
    localparam int MaxRowsDef  = 64;
    localparam int FracBitsDef = 16;
    localparam int WordW       = 32;
    localparam int IdxW        = 6;

    typedef struct packed {
        logic signed [WordW-1:0] sub_coef;
        logic signed [WordW-1:0] diag_coef;
        logic signed [WordW-1:0] super_coef;
        logic signed [WordW-1:0] rhs_value;
        logic                    last_row;
    } in_word_t;

    typedef struct packed {
        logic signed [WordW-1:0] x_value;
        logic [IdxW-1:0]         x_index;
        logic                    last_out;
        logic                    div_fault;
        logic                    saturated;
    } out_word_t;

    // arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1
    } op_t;

    typedef struct packed {
        logic sat;
        logic dz;
    } flags_t;

    // clamp a 33-bit difference to 32 bits, clamp flag in the top bit
    function automatic logic [WordW:0] sat_sub(input logic signed [WordW-1:0] a,
                                               input logic signed [WordW-1:0] b);
        logic signed [WordW:0] d;
        d = {a[WordW-1], a} - {b[WordW-1], b};
        if (d > $signed({2'b00, {(WordW-1){1'b1}}}))
            return {1'b1, 1'b0, {(WordW-1){1'b1}}};
        else if (d < $signed({2'b11, {(WordW-1){1'b0}}}))
            return {1'b1, 1'b1, {(WordW-1){1'b0}}};
        return {1'b0, d[WordW-1:0]};
    endfunction
endpackage

// ===== rtl/tds_ram.sv =====
// generic single-port-write, registered-read ram
module tds_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/tds_arith.sv =====
// bit-serial fixed-point multiply and divide unit, rounded and saturated
module tds_arith
    import tds_pkg::*;
#(
    parameter int FracBits = FracBitsDef
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  op_t                     op,
    input  logic signed [WordW-1:0] a,
    input  logic signed [WordW-1:0] b,
    output logic                    done,
    output logic signed [WordW-1:0] result,
    output flags_t                  flags
);
    localparam int AccW = 2*WordW + 2;
    localparam int DivSteps = WordW + FracBits;
    localparam int CntW = $clog2(DivSteps + 1);

    logic              busy_reg, busy_next;
    op_t               op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [AccW-1:0]   acc_reg, acc_next;     // product or quotient
    logic [AccW-1:0]   rem_reg, rem_next;     // partial remainder
    logic [AccW-1:0]   sh_reg, sh_next;       // shifted multiplicand / dividend
    logic [WordW-1:0]  mb_reg, mb_next;       // multiplier bits / divisor
    logic              done_reg, done_next;
    logic signed [WordW-1:0] res_reg, res_next;
    flags_t            fl_reg, fl_next;

    logic [WordW-1:0]  ma, mbv;
    logic [AccW-1:0]   trial, mag, rnd;

    assign ma  = a[WordW-1] ? WordW'(-a) : WordW'(a);
    assign mbv = b[WordW-1] ? WordW'(-b) : WordW'(b);

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        mb_next   = mb_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        fl_next   = '0;
        trial     = '0;
        mag       = '0;
        rnd       = '0;
        if (start)
        begin
            op_next  = op;
            neg_next = a[WordW-1] ^ b[WordW-1];
            acc_next = '0;
            rem_next = '0;
            if (op == OP_MUL)
            begin
                sh_next  = AccW'(ma);
                mb_next  = mbv;
                cnt_next = CntW'(WordW);
                busy_next = 1'b1;
            end
            else if (b == '0)
            begin
                res_next  = '0;
                fl_next.dz = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                // dividend magnitude scaled, plus half divisor for rounding
                sh_next  = (AccW'(ma) << FracBits) + AccW'(mbv >> 1);
                mb_next  = mbv;
                cnt_next = CntW'(DivSteps + 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (mb_reg[0])
                    acc_next = acc_reg + sh_reg;
                sh_next = sh_reg << 1;
                mb_next = mb_reg >> 1;
            end
            else
            begin
                // restoring division, one quotient bit a cycle, msb first
                trial = {rem_reg[AccW-2:0], sh_reg[DivSteps]};
                sh_next = sh_reg << 1;
                if (trial >= AccW'(mb_reg))
                begin
                    rem_next = trial - AccW'(mb_reg);
                    acc_next = {acc_reg[AccW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    acc_next = {acc_reg[AccW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (op_reg == OP_MUL)
                begin
                    rnd = acc_next + (AccW'(1) << (FracBits - 1));
                    mag = rnd >> FracBits;
                end
                else
                    mag = acc_next;
                if (neg_reg)
                begin
                    if (mag > (AccW'(1) << (WordW - 1)))
                    begin
                        res_next = {1'b1, {(WordW-1){1'b0}}};
                        fl_next.sat = 1'b1;
                    end
                    else
                        res_next = WordW'(-mag);
                end
                else if (mag > AccW'({1'b0, {(WordW-1){1'b1}}}))
                begin
                    res_next = {1'b0, {(WordW-1){1'b1}}};
                    fl_next.sat = 1'b1;
                end
                else
                    res_next = WordW'(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            fl_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            fl_reg   <= fl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        mb_reg  <= mb_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign flags  = fl_reg;
endmodule

// ===== rtl/tridiagonal_solver.sv =====
// tridiagonal solver top level: row intake, elimination and back substitution
//
// Thomas-algorithm solver for signed fixed-point systems of up to MaxRows rows.
// The input channel (in_valid / in_stall / in_data) carries one row per word:
// sub, diagonal, super and right-hand side coefficients plus a last-row mark.
// The first row needs no arithmetic and is written straight to the row
// stores. Each later row runs one divide (one quotient bit a cycle) and two
// multiplies (one multiplier bit a cycle) on a single shared serial unit,
// and the serial unit sets the rate. After the last row, back substitution
// emits one word per row on the output channel (out_valid / out_stall /
// out_data), index n-1 down to 0. The first word takes one divide; each
// later one a multiply and a divide. No new row is taken until the whole
// solution has been delivered. When the receiver stalls, the held output
// word stays stable and the solver waits. The row stores are plain rams
// with no reset; reset clears the row count, flags and control state. A
// row at index MaxRows-1 ends the system even without its last-row mark.
//
module tridiagonal_solver
    import tds_pkg::*;
#(
    parameter int MaxRows  = MaxRowsDef,
    parameter int FracBits = FracBitsDef
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);
    `include "assert_macros.svh"

    localparam int AW = $clog2(MaxRows);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_MULD  = 11'b00000001000,
        S_MULR  = 11'b00000010000,
        S_WR    = 11'b00000100000,
        S_BRD   = 11'b00001000000,
        S_BMUL  = 11'b00010000000,
        S_BDIV  = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     row_reg, row_next;
    logic [AW-1:0]     k_reg, k_next;
    flags_t            fl_reg, fl_next;
    logic signed [WordW-1:0] x_reg, x_next;
    logic signed [WordW-1:0] f_reg, f_next;
    logic signed [WordW-1:0] dnew_reg, dnew_next;
    in_word_t          row_in_reg, row_in_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    out_word_t         out_reg, out_next;
    logic              ov_reg, ov_next;

    logic              a_start, a_done;
    op_t               a_op;
    logic signed [WordW-1:0] a_a, a_b, a_res;
    flags_t            a_fl;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [WordW-1:0]  d_w, r_w, s_w, d_q, r_q, s_q;
    logic [WordW:0]    sub_res;

    tds_ram #(.Width(WordW), .Depth(MaxRows)) u_diag (
        .clk(clk), .we(we), .waddr(waddr), .wdata(d_w), .raddr(raddr), .rdata(d_q));
    tds_ram #(.Width(WordW), .Depth(MaxRows)) u_rhs (
        .clk(clk), .we(we), .waddr(waddr), .wdata(r_w), .raddr(raddr), .rdata(r_q));
    tds_ram #(.Width(WordW), .Depth(MaxRows)) u_sup (
        .clk(clk), .we(we), .waddr(waddr), .wdata(s_w), .raddr(raddr), .rdata(s_q));

    tds_arith #(.FracBits(FracBits)) u_arith (
        .clk(clk), .rst_n(rst_n), .start(a_start), .op(a_op), .a(a_a), .b(a_b),
        .done(a_done), .result(a_res), .flags(a_fl));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        k_next      = k_reg;
        fl_next     = fl_reg;
        x_next      = x_reg;
        f_next      = f_reg;
        dnew_next   = dnew_reg;
        row_in_next = row_in_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        a_start     = 1'b0;
        a_op        = OP_MUL;
        a_a         = '0;
        a_b         = '0;
        we          = 1'b0;
        waddr       = row_in_reg.last_row ? row_reg : row_reg;
        d_w         = row_in_reg.diag_coef;
        r_w         = row_in_reg.rhs_value;
        s_w         = row_in_reg.super_coef;
        raddr       = row_reg - AW'(1);
        sub_res     = '0;
        if (a_done)
            fl_next = fl_next | a_fl;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    row_in_next = in_data;
                    last_next   = in_data.last_row || (row_reg == AW'(MaxRows - 1));
                    state_next  = (first_reg) ? S_WR : S_RD;
                end
            end
            S_RD:
            begin
                // ram read of row-1 settles this cycle
                state_next = S_DIV;
            end
            S_DIV:
            begin
                a_start = 1'b1;
                a_op    = OP_DIV;
                a_a     = row_in_reg.sub_coef;
                a_b     = d_q;
                state_next = S_MULD;
            end
            S_MULD:
            begin
                if (a_done && !a_start)
                begin
                    f_next  = a_res;
                    a_start = 1'b1;
                    a_op    = OP_MUL;
                    a_a     = a_res;
                    a_b     = s_q;
                    state_next = S_MULR;
                end
            end
            S_MULR:
            begin
                if (a_done)
                begin
                    sub_res   = sat_sub(row_in_reg.diag_coef, a_res);
                    dnew_next = sub_res[WordW-1:0];
                    fl_next.sat = fl_next.sat | sub_res[WordW];
                    a_start = 1'b1;
                    a_op    = OP_MUL;
                    a_a     = f_reg;
                    a_b     = r_q;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (first_reg || a_done)
                begin
                    we = 1'b1;
                    if (!first_reg)
                    begin
                        d_w = dnew_reg;
                        sub_res = sat_sub(row_in_reg.rhs_value, a_res);
                        r_w = sub_res[WordW-1:0];
                        fl_next.sat = fl_next.sat | sub_res[WordW];
                    end
                    if (last_reg)
                    begin
                        k_next = row_reg;
                        state_next = S_BRD;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + AW'(1);
                        first_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_BRD:
            begin
                raddr = k_reg;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                raddr = k_reg;
                if (k_reg == row_reg)
                begin
                    a_start = 1'b1;
                    a_op    = OP_DIV;
                    a_a     = r_q;
                    a_b     = d_q;
                    state_next = S_OUT;
                end
                else
                begin
                    a_start = 1'b1;
                    a_op    = OP_MUL;
                    a_a     = s_q;
                    a_b     = x_reg;
                    state_next = S_BDIV;
                end
            end
            S_BDIV:
            begin
                raddr = k_reg;
                if (a_done)
                begin
                    sub_res = sat_sub(r_q, a_res);
                    fl_next.sat = fl_next.sat | sub_res[WordW];
                    a_start = 1'b1;
                    a_op    = OP_DIV;
                    a_a     = sub_res[WordW-1:0];
                    a_b     = d_q;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                raddr = k_reg;
                if (a_done)
                begin
                    x_next = a_res;
                    out_next.x_value   = a_res;
                    out_next.x_index   = IdxW'(k_reg);
                    out_next.last_out  = (k_reg == '0);
                    out_next.div_fault = fl_next.dz;
                    out_next.saturated = fl_next.sat;
                    ov_next    = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                raddr = k_reg - AW'(1);
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (k_reg == '0)
                    begin
                        row_next = '0;
                        fl_next  = '0;
                        x_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg - AW'(1);
                        state_next = S_BRD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            k_reg     <= '0;
            fl_reg    <= '0;
            x_reg     <= '0;
            first_reg <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            fl_reg    <= fl_next;
            x_reg     <= x_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg      <= f_next;
        dnew_reg   <= dnew_next;
        row_in_reg <= row_in_next;
        last_reg   <= last_next;
        out_reg    <= out_next;
    end

    `CHECK_ALWAYS(a_out_only_wait, !out_valid || state_reg == S_WAIT, "output valid outside wait")
    `CHECK_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled word changed")
    `CHECK_NEXT(a_last_done, out_valid && !out_stall && out_data.last_out, state_reg == S_IDLE && row_reg == '0, "solve not closed after last word")
endmodule
